// File: hw/rtl/pbwg_pkg.sv
// Shared types and constants for the power button wake gesture gate.
// Holds the register map, the configuration and result structs and the verdict codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbwg_pkg;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SHORT_PRESS_EN  = 3'd0;
  localparam logic [2:0] REG_LONG_HOLD_EN    = 3'd1;
  localparam logic [2:0] REG_DOUBLE_CLICK_EN = 3'd2;
  localparam logic [2:0] REG_REQUIRED_HOLD   = 3'd3;
  localparam logic [2:0] REG_BOUNCE_TOL      = 3'd4;
  localparam logic [2:0] REG_RELEASE_DEB     = 3'd5;
  localparam logic [2:0] REG_DOUBLE_WINDOW   = 3'd6;

  localparam logic [15:0] REQUIRED_HOLD_RST = 16'd1000;
  localparam logic [15:0] BOUNCE_TOL_RST    = 16'd100;
  localparam logic [15:0] RELEASE_DEB_RST   = 16'd30;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;

  localparam logic [15:0] SAT16_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    VERDICT_NOT_PRESSED = 3'd0,
    VERDICT_SHORT       = 3'd1,
    VERDICT_LONG_HOLD   = 3'd2,
    VERDICT_DOUBLE      = 3'd3,
    VERDICT_EARLY       = 3'd4,
    VERDICT_NO_SECOND   = 3'd5
  } verdict_t;

  typedef struct packed {
    logic        short_press_enabled;
    logic        long_hold_enabled;
    logic        double_click_enabled;
    logic [15:0] required_hold_ms;
    logic [15:0] early_release_ms;
    logic [15:0] repress_gap_ms;
    logic [15:0] second_press_window_ms;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    verdict_t    verdict;
    logic [15:0] decided_at_ms;
    logic [15:0] held_ms;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pbwg_cfg_regs.sv
// APB-style configuration register file for the wake gesture gate.
// Depends on pbwg_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module pbwg_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pbwg_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [pbwg_pkg::DATA_BITS-1:0] pwdata,
  output logic      [pbwg_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready,
  output pbwg_pkg::cfg_t                      cfg
);

  pbwg_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[pbwg_pkg::ADDR_BITS-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_enabled    <= 1'b0;
      cfg_r.long_hold_enabled      <= 1'b1;
      cfg_r.double_click_enabled   <= 1'b0;
      cfg_r.required_hold_ms       <= pbwg_pkg::REQUIRED_HOLD_RST;
      cfg_r.early_release_ms       <= pbwg_pkg::BOUNCE_TOL_RST;
      cfg_r.repress_gap_ms         <= pbwg_pkg::RELEASE_DEB_RST;
      cfg_r.second_press_window_ms <= pbwg_pkg::DOUBLE_WINDOW_RST;
    end else if (wr_en) begin
      case (reg_idx)
        pbwg_pkg::REG_SHORT_PRESS_EN:  cfg_r.short_press_enabled    <= pwdata[0];
        pbwg_pkg::REG_LONG_HOLD_EN:    cfg_r.long_hold_enabled      <= pwdata[0];
        pbwg_pkg::REG_DOUBLE_CLICK_EN: cfg_r.double_click_enabled   <= pwdata[0];
        pbwg_pkg::REG_REQUIRED_HOLD:   cfg_r.required_hold_ms       <= pwdata[15:0];
        pbwg_pkg::REG_BOUNCE_TOL:      cfg_r.early_release_ms       <= pwdata[15:0];
        pbwg_pkg::REG_RELEASE_DEB:     cfg_r.repress_gap_ms         <= pwdata[15:0];
        pbwg_pkg::REG_DOUBLE_WINDOW:   cfg_r.second_press_window_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      pbwg_pkg::REG_SHORT_PRESS_EN:  prdata[0]    = cfg_r.short_press_enabled;
      pbwg_pkg::REG_LONG_HOLD_EN:    prdata[0]    = cfg_r.long_hold_enabled;
      pbwg_pkg::REG_DOUBLE_CLICK_EN: prdata[0]    = cfg_r.double_click_enabled;
      pbwg_pkg::REG_REQUIRED_HOLD:   prdata[15:0] = cfg_r.required_hold_ms;
      pbwg_pkg::REG_BOUNCE_TOL:      prdata[15:0] = cfg_r.early_release_ms;
      pbwg_pkg::REG_RELEASE_DEB:     prdata[15:0] = cfg_r.repress_gap_ms;
      pbwg_pkg::REG_DOUBLE_WINDOW:   prdata[15:0] = cfg_r.second_press_window_ms;
      default:                       prdata       = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/pbwg_core.sv
// Gesture classifier: gate state registers and the single-pass decision logic.
// Depends on pbwg_pkg for cfg_t, result_t and the verdict codes.
`timescale 1ns / 1ps
`default_nettype none

module pbwg_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 pin_pressed,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire pbwg_pkg::cfg_t       cfg,
  output pbwg_pkg::result_t         res
);

  localparam logic [TIME_BITS-1:0] SAT_LIMIT = TIME_BITS'(pbwg_pkg::SAT16_MAX);

  logic                 active_r, active_nxt;
  logic                 seen_r, seen_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [TIME_BITS-1:0] rel_start_r, rel_start_nxt;

  logic                 eff_seen;
  logic [TIME_BITS-1:0] eff_rel_start;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] gap;
  logic [TIME_BITS-1:0] since_start;
  logic [TIME_BITS-1:0] held_out;
  logic                 emit;
  pbwg_pkg::verdict_t   verdict;

  always_comb begin
    // An idle gate opens on this sample: times start from now, no release pending
    start_nxt     = active_r ? start_r : now;
    last_nxt      = active_r ? last_r : now;
    eff_seen      = active_r & seen_r;
    eff_rel_start = active_r ? rel_start_r : '0;

    held        = last_nxt - start_nxt;
    since_start = now - start_nxt;
    gap         = now - eff_rel_start;

    active_nxt    = active_r;
    seen_nxt      = eff_seen;
    rel_start_nxt = eff_rel_start;
    emit          = 1'b0;
    verdict       = pbwg_pkg::VERDICT_NOT_PRESSED;
    held_out      = '0;

    if (!active_r && !pin_pressed) begin
      emit = 1'b1;
    end else if (!active_r && cfg.short_press_enabled) begin
      emit    = 1'b1;
      verdict = pbwg_pkg::VERDICT_SHORT;
    end else begin
      active_nxt = 1'b1;
      if (pin_pressed) begin
        if (eff_seen && cfg.double_click_enabled &&
            gap >= TIME_BITS'(cfg.repress_gap_ms)) begin
          emit     = 1'b1;
          verdict  = pbwg_pkg::VERDICT_DOUBLE;
          held_out = held;
        end else begin
          // Drop a short release as bounce and keep following the press
          seen_nxt = 1'b0;
          last_nxt = now;
          if (cfg.long_hold_enabled && now >= TIME_BITS'(cfg.required_hold_ms)) begin
            emit     = 1'b1;
            verdict  = pbwg_pkg::VERDICT_LONG_HOLD;
            held_out = since_start;
          end
        end
      end else begin
        seen_nxt = 1'b1;
        if (!eff_seen) begin
          rel_start_nxt = now;
        end
        held_out = held;
        if (!cfg.double_click_enabled) begin
          if ((now - rel_start_nxt) >= TIME_BITS'(cfg.early_release_ms)) begin
            emit    = 1'b1;
            verdict = pbwg_pkg::VERDICT_EARLY;
          end
        end else if ((now - rel_start_nxt) >= TIME_BITS'(cfg.second_press_window_ms)) begin
          emit    = 1'b1;
          verdict = pbwg_pkg::VERDICT_NO_SECOND;
        end
      end
    end

    if (emit) begin
      active_nxt = 1'b0;
      seen_nxt   = 1'b0;
    end

    res.emit          = emit;
    res.verdict       = verdict;
    res.decided_at_ms = (now > SAT_LIMIT) ? pbwg_pkg::SAT16_MAX : now[15:0];
    res.held_ms       = (held_out > SAT_LIMIT) ? pbwg_pkg::SAT16_MAX : held_out[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      seen_r   <= 1'b0;
    end else if (step) begin
      active_r <= active_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // Times are only read while the gate or the release flag says they are live
  always_ff @(posedge clk) begin
    if (step) begin
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      rel_start_r <= rel_start_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/power_button_wake_gesture_gate.sv
// Power button wake gesture gate, top level.
// A sample is held in the sample register, classified by the core and its result is
// captured in the result register. Throughput: one sample per cycle unless a result waits
// on a blocked output; set by the one pass from sample register to result register.
// Reset (synchronous, rst_n low): gate idle, no release pending, registers to defaults.
// Depends on pbwg_pkg, pbwg_cfg_regs and pbwg_core.
`timescale 1ns / 1ps
`default_nettype none

module power_button_wake_gesture_gate #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_pin_pressed,
  input  wire logic [31:0]                    in_now_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          out_verdict,
  output logic [15:0]                         out_decided_at_ms,
  output logic [15:0]                         out_held_ms,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pbwg_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [pbwg_pkg::DATA_BITS-1:0] pwdata,
  output logic      [pbwg_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready
);

  pbwg_pkg::cfg_t    cfg;
  pbwg_pkg::result_t res;

  logic        smp_valid_r;
  logic        smp_pin_r;
  logic [31:0] smp_now_r;
  logic        step;

  logic        out_valid_r;
  logic [2:0]  out_verdict_r;
  logic [15:0] out_at_r;
  logic [15:0] out_held_r;

  pbwg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbwg_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .pin_pressed (smp_pin_r),
    .now         (TIME_BITS'(smp_now_r)),
    .cfg         (cfg),
    .res         (res)
  );

  // Advance the held sample unless it has a result and the result slot is blocked
  assign step     = smp_valid_r & (~res.emit | ~out_valid_r | out_ready);
  assign in_ready = ~smp_valid_r | step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ready) begin
      smp_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_pin_r <= in_pin_pressed;
      smp_now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_verdict_r <= res.verdict;
      out_at_r      <= res.decided_at_ms;
      out_held_r    <= res.held_ms;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_decided_at_ms = out_at_r;
  assign out_held_ms       = out_held_r;

endmodule

`default_nettype wire

// File: sim/tb_power_button_wake_gesture_gate.sv
// Self-checking testbench for the power button wake gesture gate.
// Drives pin samples and register writes, predicts each verdict in step and checks every
// result transfer. Depends on pbwg_pkg and power_button_wake_gesture_gate.
`timescale 1ns / 1ps

module tb_power_button_wake_gesture_gate;
  import pbwg_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_SAMPLES  = 240;
  localparam int unsigned QUIET_PHASE    = 4;
  localparam logic [2:0]  REG_SPARE      = 3'd7;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] decided_at;
    logic [15:0] held;
  } wake_result_t;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   reg_idx;
    logic [31:0]  value;
    logic         pressed;
    logic         typed;
    wake_result_t res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_pin_pressed = 1'b0;
  logic [31:0]          in_now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_verdict;
  logic [15:0]          out_decided_at_ms;
  logic [15:0]          out_held_ms;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Gesture tracker shadow
  cfg_t        shadow_cfg;
  logic        gate_open;
  logic [31:0] gate_start;
  logic [31:0] last_press;
  logic [31:0] rel_start;
  logic        rel_seen;

  wake_result_t expected_results[$];
  stim_row_t    directed_rows[$];
  logic         typed_valid = 1'b0;
  wake_result_t typed_res;
  logic         quiet = 1'b0;
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  samples_sent = 0;

  // Monitor scratch
  wake_result_t seen_exp;
  wake_result_t seen_pred;
  logic         seen_hit;
  logic         seen_transfer;

  power_button_wake_gesture_gate u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pin_pressed    (in_pin_pressed),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .out_decided_at_ms (out_decided_at_ms),
    .out_held_ms       (out_held_ms),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] clip16(input logic [31:0] x);
    return (x > 32'(SAT16_MAX)) ? SAT16_MAX : x[15:0];
  endfunction

  // Close the gate and build the verdict
  function automatic wake_result_t conclude(input verdict_t v, input logic [31:0] at,
                                            input logic [31:0] held);
    wake_result_t r;
    r.verdict    = v;
    r.decided_at = clip16(at);
    r.held       = clip16(held);
    gate_open    = 1'b0;
    rel_seen     = 1'b0;
    return r;
  endfunction

  // Advance the tracker by one sample; returns 1 when a verdict is reached
  function automatic logic classify_sample(input logic pressed, input logic [31:0] now,
                                           output wake_result_t res);
    logic [31:0] held;
    logic [31:0] span;
    res = '0;
    if (!gate_open) begin
      gate_start = now;
      last_press = now;
      rel_start  = '0;
      rel_seen   = 1'b0;
      if (!pressed) begin
        res = conclude(VERDICT_NOT_PRESSED, now, 32'd0);
        return 1'b1;
      end
      if (shadow_cfg.short_press_enabled) begin
        res = conclude(VERDICT_SHORT, now, 32'd0);
        return 1'b1;
      end
      gate_open = 1'b1;
    end
    held = last_press - gate_start;
    if (pressed) begin
      if (rel_seen) begin
        span = now - rel_start;
        if (shadow_cfg.double_click_enabled && span >= 32'(shadow_cfg.repress_gap_ms)) begin
          res = conclude(VERDICT_DOUBLE, now, held);
          return 1'b1;
        end
        // too soon after the release: treat it as bounce
        rel_seen = 1'b0;
      end
      last_press = now;
      if (shadow_cfg.long_hold_enabled && now >= 32'(shadow_cfg.required_hold_ms)) begin
        res = conclude(VERDICT_LONG_HOLD, now, now - gate_start);
        return 1'b1;
      end
    end else begin
      if (!rel_seen) begin
        rel_start = now;
        rel_seen  = 1'b1;
      end
      span = now - rel_start;
      if (!shadow_cfg.double_click_enabled) begin
        if (span >= 32'(shadow_cfg.early_release_ms)) begin
          res = conclude(VERDICT_EARLY, now, held);
          return 1'b1;
        end
      end else if (span >= 32'(shadow_cfg.second_press_window_ms)) begin
        res = conclude(VERDICT_NO_SECOND, now, held);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    if (want !== got) begin
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 21);

  // Check result transfers, then predict sample transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      seen_transfer = 1'b0;
      if (out_valid && out_ready) begin
        seen_transfer = 1'b1;
        if (expected_results.size() == 0) begin
          $display("[%0t] unexpected result: verdict %0d, at %0d, held %0d", $time,
                   out_verdict, out_decided_at_ms, out_held_ms);
          mismatches++;
        end else begin
          seen_exp = expected_results.pop_front();
          flag_field("verdict", 16'(seen_exp.verdict), 16'(out_verdict));
          flag_field("decided_at_ms", seen_exp.decided_at, out_decided_at_ms);
          flag_field("held_ms", seen_exp.held, out_held_ms);
        end
      end
      if (in_valid && in_ready) begin
        seen_transfer = 1'b1;
        seen_hit = classify_sample(in_pin_pressed, in_now_ms, seen_pred);
        if (seen_hit || typed_valid)
          expected_results.push_back(typed_valid ? typed_res : seen_pred);
      end
      if (seen_transfer) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge; leaves valid high for the caller to replace
  task automatic send_sample(input logic pressed, input logic [31:0] now);
    while (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_pin_pressed = pressed;
    in_now_ms      = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_SHORT_PRESS_EN:  shadow_cfg.short_press_enabled    = value[0];
      REG_LONG_HOLD_EN:    shadow_cfg.long_hold_enabled      = value[0];
      REG_DOUBLE_CLICK_EN: shadow_cfg.double_click_enabled   = value[0];
      REG_REQUIRED_HOLD:   shadow_cfg.required_hold_ms       = value[15:0];
      REG_BOUNCE_TOL:      shadow_cfg.early_release_ms       = value[15:0];
      REG_RELEASE_DEB:     shadow_cfg.repress_gap_ms         = value[15:0];
      REG_DOUBLE_WINDOW:   shadow_cfg.second_press_window_ms = value[15:0];
      default: ;
    endcase
  endtask

  function automatic void row_sample(input logic pressed, input logic [31:0] now);
    stim_row_t r;
    r = '{ROW_SAMPLE, REG_SPARE, now, pressed, 1'b0, '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void row_typed(input logic pressed, input logic [31:0] now,
                                    input verdict_t v, input logic [15:0] at,
                                    input logic [15:0] held);
    stim_row_t r;
    r = '{ROW_SAMPLE, REG_SPARE, now, pressed, 1'b1, '{v, at, held}};
    directed_rows.push_back(r);
  endfunction

  function automatic void row_write(input logic [2:0] idx, input logic [31:0] value);
    stim_row_t r;
    r = '{ROW_WRITE, idx, value, 1'b0, 1'b0, '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    // writes to the unused index must change nothing
    row_write(REG_SPARE, 32'hFFFF_FFFF);
    row_typed(1'b0, 32'd5, VERDICT_NOT_PRESSED, 16'd5, 16'd0);
    row_typed(1'b0, 32'hFFFF_FFFF, VERDICT_NOT_PRESSED, SAT16_MAX, 16'd0);
    row_typed(1'b1, 32'd1000, VERDICT_LONG_HOLD, 16'd1000, 16'd0);
    // press, then a release that outlasts the bounce tolerance
    row_sample(1'b1, 32'd10);
    row_sample(1'b1, 32'd400);
    row_sample(1'b0, 32'd450);
    row_sample(1'b0, 32'd549);
    row_typed(1'b0, 32'd550, VERDICT_EARLY, 16'd550, 16'd390);
    row_sample(1'b1, 32'd0);
    row_typed(1'b1, 32'h0010_0000, VERDICT_LONG_HOLD, SAT16_MAX, SAT16_MAX);
    row_typed(1'b1, 32'hFFFF_FF00, VERDICT_LONG_HOLD, SAT16_MAX, 16'd0);
    row_write(REG_SHORT_PRESS_EN, 32'd1);
    row_typed(1'b1, 32'd7, VERDICT_SHORT, 16'd7, 16'd0);
    row_typed(1'b0, 32'd8, VERDICT_NOT_PRESSED, 16'd8, 16'd0);
    row_write(REG_SHORT_PRESS_EN, 32'd0);
    row_write(REG_DOUBLE_CLICK_EN, 32'd1);
    row_write(REG_LONG_HOLD_EN, 32'd0);
    // clean double click
    row_sample(1'b1, 32'd100);
    row_sample(1'b1, 32'd160);
    row_sample(1'b0, 32'd200);
    row_sample(1'b1, 32'd240);
    // re-press inside the debounce gap is bounce, then the window runs out
    row_sample(1'b1, 32'd300);
    row_sample(1'b0, 32'd310);
    row_sample(1'b1, 32'd320);
    row_sample(1'b0, 32'd400);
    row_sample(1'b0, 32'd700);
    row_write(REG_RELEASE_DEB, 32'd0);
    row_write(REG_DOUBLE_WINDOW, 32'd0);
    row_sample(1'b1, 32'd50);
    row_sample(1'b0, 32'd60);
    row_write(REG_DOUBLE_CLICK_EN, 32'd0);
    row_write(REG_BOUNCE_TOL, 32'd0);
    row_sample(1'b1, 32'd90);
    row_sample(1'b0, 32'd95);
    row_write(REG_LONG_HOLD_EN, 32'd1);
    row_write(REG_REQUIRED_HOLD, 32'd0);
    row_typed(1'b1, 32'd0, VERDICT_LONG_HOLD, 16'd0, 16'd0);
  endfunction

  function automatic logic [15:0] pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 22) return SAT16_MAX;
    return 16'($urandom_range(1, 400));
  endfunction

  function automatic logic [31:0] pick_start();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 1500);
    if (r < 70) return $urandom_range(0, 70000);
    if (r < 85) return $urandom_range(32'hFFFF_F000, 32'hFFFF_FFFF);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 120);
    if (r < 95) return $urandom_range(0, 600);
    return $urandom();
  endfunction

  task automatic configure_phase(input int unsigned phase);
    logic        short_en, long_en, dbl_en;
    logic [15:0] hold, bounce, deb, window;
    case (phase)
      0: begin
        short_en = 1'b0; long_en = 1'b1; dbl_en = 1'b1;
        hold = 16'd0; bounce = 16'd0; deb = 16'd0; window = 16'd0;
      end
      1: begin
        short_en = 1'b0; long_en = 1'b1; dbl_en = 1'b0;
        hold = SAT16_MAX; bounce = SAT16_MAX; deb = SAT16_MAX; window = SAT16_MAX;
      end
      default: begin
        short_en = ($urandom_range(0, 99) < 15);
        long_en  = ($urandom_range(0, 99) < 70);
        dbl_en   = 1'($urandom_range(0, 1));
        hold     = ($urandom_range(0, 9) == 0) ? pick_span() : 16'($urandom_range(0, 2000));
        bounce   = pick_span();
        deb      = pick_span();
        window   = pick_span();
      end
    endcase
    // upper bits carry noise that must be dropped
    write_reg(REG_SHORT_PRESS_EN, ($urandom() & 32'hFFFF_FFFE) | 32'(short_en));
    write_reg(REG_LONG_HOLD_EN, ($urandom() & 32'hFFFF_FFFE) | 32'(long_en));
    write_reg(REG_DOUBLE_CLICK_EN, ($urandom() & 32'hFFFF_FFFE) | 32'(dbl_en));
    write_reg(REG_REQUIRED_HOLD, ($urandom() & 32'hFFFF_0000) | 32'(hold));
    write_reg(REG_BOUNCE_TOL, ($urandom() & 32'hFFFF_0000) | 32'(bounce));
    write_reg(REG_RELEASE_DEB, ($urandom() & 32'hFFFF_0000) | 32'(deb));
    write_reg(REG_DOUBLE_WINDOW, ($urandom() & 32'hFFFF_0000) | 32'(window));
    write_reg(REG_SPARE, $urandom());
  endtask

  // Press, release and an optional second press, with random timing; or one to four random samples
  task automatic play_gesture();
    logic [31:0] t;
    int unsigned n, i;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) send_sample(1'($urandom_range(0, 1)), $urandom());
    end else begin
      t = pick_start();
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        send_sample(1'b1, t);
        t += pick_step();
      end
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        send_sample(1'b0, t);
        t += pick_step();
      end
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          send_sample(1'b1, t);
          t += pick_step();
        end
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
          send_sample(1'b0, t);
          t += pick_step();
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_end;
    shadow_cfg = '{1'b0, 1'b1, 1'b0, REQUIRED_HOLD_RST, BOUNCE_TOL_RST, RELEASE_DEB_RST,
                   DOUBLE_WINDOW_RST};
    gate_open  = 1'b0;
    gate_start = '0;
    last_press = '0;
    rel_start  = '0;
    rel_seen   = 1'b0;
    build_directed();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_for_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        typed_valid = directed_rows[i].typed;
        typed_res   = directed_rows[i].res;
        send_sample(directed_rows[i].pressed, directed_rows[i].value);
      end
    end
    typed_valid = 1'b0;

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      // hold the sender until the gate has delivered everything
      wait_for_results();
      configure_phase(phase);
      quiet     = (phase == QUIET_PHASE);
      phase_end = samples_sent + PHASE_SAMPLES;
      while (samples_sent < phase_end) play_gesture();
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
